// ----- hw/rtl/luhn_pkg.sv -----
// Shared constants, types and command bundle for the Luhn card classifier.
`default_nettype none
package luhn_pkg;

  localparam int NumBits      = 63;
  localparam int NumDigits    = 19;
  localparam int BcdWidth     = 4 * NumDigits;
  localparam int BitsPerStep  = 3;
  localparam int ConvSteps    = NumBits / BitsPerStep;
  localparam int StepCntWidth = 5;

  localparam logic [1:0] ClassInvalid = 2'd0;
  localparam logic [1:0] ClassVisa    = 2'd1;
  localparam logic [1:0] ClassMaster  = 2'd2;
  localparam logic [1:0] ClassAmex    = 2'd3;

  localparam logic [3:0] VisaLead     = 4'd4;
  localparam logic [4:0] VisaMinLen   = 5'd13;
  localparam logic [4:0] VisaMaxLen   = 5'd16;
  localparam logic [4:0] MasterLen    = 5'd16;
  localparam logic [6:0] MasterLo     = 7'd51;
  localparam logic [6:0] MasterHi     = 7'd55;
  localparam logic [4:0] AmexLen      = 5'd15;
  localparam logic [6:0] AmexLeadA    = 7'd34;
  localparam logic [6:0] AmexLeadB    = 7'd37;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                    load;
    logic                    conv;
    logic                    scan;
    logic [StepCntWidth-1:0] idx;
  } dp_cmd_t;

endpackage
`default_nettype wire

// ----- hw/rtl/luhn_ctrl.sv -----
// Controller: sequences binary-to-BCD conversion and the digit scan.
`default_nettype none
module luhn_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  output logic                   out_valid,
  output luhn_pkg::dp_cmd_t      cmd
);

  luhn_pkg::state_t state_r, state_nxt;
  logic [luhn_pkg::StepCntWidth-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= luhn_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.idx   = cnt_r;
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      luhn_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = luhn_pkg::ST_CONV;
        end
      end
      luhn_pkg::ST_CONV: begin
        cmd.conv = 1'b1;
        if (cnt_r == luhn_pkg::StepCntWidth'(luhn_pkg::ConvSteps - 1)) begin
          cnt_nxt   = '0;
          state_nxt = luhn_pkg::ST_SCAN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      luhn_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (cnt_r == luhn_pkg::StepCntWidth'(luhn_pkg::NumDigits - 1)) begin
          cnt_nxt   = '0;
          state_nxt = luhn_pkg::ST_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      luhn_pkg::ST_DONE: begin
        out_valid = 1'b1;
        state_nxt = luhn_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = luhn_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- hw/rtl/luhn_dp.sv -----
// Datapath: double-dabble BCD conversion, digit scan, Luhn sum and classing.
`default_nettype none
module luhn_dp (
  input  wire logic                          clk,
  input  wire luhn_pkg::dp_cmd_t             cmd,
  input  wire logic [luhn_pkg::NumBits-1:0]  card_number,
  output logic [1:0]                         card_class,
  output logic                               luhn_ok,
  output logic [4:0]                         digit_count
);

  logic [luhn_pkg::NumBits-1:0]  bin_r, bin_nxt;
  logic [luhn_pkg::BcdWidth-1:0] bcd_r, bcd_nxt;
  logic [3:0] sum_r, sum_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic [3:0] top1_r, top1_nxt;
  logic [6:0] top2_r, top2_nxt;
  logic [3:0] prev_r, prev_nxt;

  logic [luhn_pkg::BcdWidth-1:0] dab;
  logic [3:0] dig;
  logic [3:0] contrib;
  logic [4:0] sum_raw;

  always_ff @(posedge clk) begin
    bin_r  <= bin_nxt;
    bcd_r  <= bcd_nxt;
    sum_r  <= sum_nxt;
    cnt_r  <= cnt_nxt;
    top1_r <= top1_nxt;
    top2_r <= top2_nxt;
    prev_r <= prev_nxt;
  end

  // three dabble bit steps per cycle
  always_comb begin
    dab = bcd_r;
    for (int k = 0; k < luhn_pkg::BitsPerStep; k++) begin
      for (int j = 0; j < luhn_pkg::NumDigits; j++) begin
        if (dab[4*j +: 4] >= 4'd5) begin
          dab[4*j +: 4] = dab[4*j +: 4] + 4'd3;
        end
      end
      dab = {dab[luhn_pkg::BcdWidth-2:0], bin_r[luhn_pkg::NumBits-1-k]};
    end
  end

  assign dig = bcd_r[3:0];

  always_comb begin
    if (cmd.idx[0]) begin
      contrib = (dig < 4'd5) ? 4'(dig << 1) : 4'((dig << 1) - 5'd9);
    end else begin
      contrib = dig;
    end
    sum_raw = {1'b0, sum_r} + {1'b0, contrib};
  end

  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    sum_nxt  = sum_r;
    cnt_nxt  = cnt_r;
    top1_nxt = top1_r;
    top2_nxt = top2_r;
    prev_nxt = prev_r;
    if (cmd.load) begin
      bin_nxt  = card_number;
      bcd_nxt  = '0;
      sum_nxt  = '0;
      cnt_nxt  = '0;
      top1_nxt = '0;
      top2_nxt = '0;
      prev_nxt = '0;
    end else if (cmd.conv) begin
      bin_nxt = bin_r << luhn_pkg::BitsPerStep;
      bcd_nxt = dab;
    end else if (cmd.scan) begin
      bcd_nxt  = bcd_r >> 4;
      sum_nxt  = (sum_raw >= 5'd10) ? 4'(sum_raw - 5'd10) : sum_raw[3:0];
      prev_nxt = dig;
      if (dig != 4'd0) begin
        cnt_nxt  = cmd.idx + 1'b1;
        top1_nxt = dig;
        top2_nxt = 7'({dig, 3'b000}) + 7'({dig, 1'b0}) + 7'(prev_r);
      end
    end
  end

  always_comb begin
    luhn_ok     = (sum_r == 4'd0);
    digit_count = cnt_r;
    card_class  = luhn_pkg::ClassInvalid;
    if (cnt_r != 5'd0 && luhn_ok) begin
      if (top1_r == luhn_pkg::VisaLead &&
          cnt_r inside {[luhn_pkg::VisaMinLen:luhn_pkg::VisaMaxLen]}) begin
        card_class = luhn_pkg::ClassVisa;
      end else if (cnt_r == luhn_pkg::MasterLen &&
                   top2_r inside {[luhn_pkg::MasterLo:luhn_pkg::MasterHi]}) begin
        card_class = luhn_pkg::ClassMaster;
      end else if (cnt_r == luhn_pkg::AmexLen &&
                   (top2_r == luhn_pkg::AmexLeadA || top2_r == luhn_pkg::AmexLeadB)) begin
        card_class = luhn_pkg::ClassAmex;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/luhn_card_classifier.sv -----
// Luhn card classifier: 63-bit binary to 19 BCD digits, Luhn check, card class.
// 21 double-dabble steps (3 bits each), then 19 digit-scan steps, one digit per
// cycle, then the done state with the result; a new card is taken only in idle.
// Results come as a one-cycle out_valid strobe; the receiver cannot stall.
// Reset (rst_n low, synchronous) returns the controller to idle, busy low.
`default_nettype none
module luhn_card_classifier (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [luhn_pkg::NumBits-1:0] in_card_number,
  output logic                              out_valid,
  output logic [1:0]                        out_card_class,
  output logic                              out_luhn_ok,
  output logic [4:0]                        out_digit_count
);

  luhn_pkg::dp_cmd_t cmd;

  luhn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  luhn_dp u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .card_number (in_card_number),
    .card_class  (out_card_class),
    .luhn_ok     (out_luhn_ok),
    .digit_count (out_digit_count)
  );

endmodule
`default_nettype wire
